@@ src/mbrtu_pkg.sv @@
package mbrtu_pkg;

   localparam logic [15:0] CRC_POLY      = 16'hA001;
   localparam logic [15:0] CRC_PRESET    = 16'hFFFF;
   localparam logic [7:0]  BASE_COUNT    = 8'd5;
   localparam logic [7:0]  FN_WRITE_MULT = 8'h10;
   localparam logic [7:0]  BCAST_ADDR    = 8'h00;
   localparam logic [7:0]  OWN_ADDR_RESET = 8'd2;

   localparam logic KIND_BYTE    = 1'b0;
   localparam logic KIND_SILENCE = 1'b1;

   localparam int  CSR_ADDR_W = 2;
   localparam logic [CSR_ADDR_W-1:0] CSR_OWN_ADDRESS = 2'd0;

   localparam int RSP_DATA_W = 24;

   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_FUNC    = 3'd1,
      PH_DATA    = 3'd2,
      PH_EXTRA   = 3'd3,
      PH_CRCL    = 3'd4,
      PH_CRCH    = 3'd5,
      PH_DISCARD = 3'd6
   } phase_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] rx_byte;
   } item_type;

   typedef struct packed {
      logic       payload_valid;
      logic [7:0] payload_byte;
      logic       frame_end;
      logic       crc_ok;
      logic [7:0] function_code;
      logic       is_broadcast;
      logic       frame_dropped;
   } result_type;

   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

@@ src/mbrtu_csr.sv @@
module mbrtu_csr
   import mbrtu_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready,
   output logic [7:0]            own_address
);

   logic [7:0] own_address_ff;
   logic [7:0] own_address_in;
   logic       wr_en;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      own_address_in = own_address_ff;
      if (wr_en && (csr_paddr == CSR_OWN_ADDRESS)) begin
         own_address_in = csr_pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_address_ff <= OWN_ADDR_RESET;
      end else begin
         own_address_ff <= own_address_in;
      end
   end

   always_comb begin
      unique case (csr_paddr)
         CSR_OWN_ADDRESS: csr_prdata = {24'h000000, own_address_ff};
         default:         csr_prdata = 32'h00000000;
      endcase
   end

   assign own_address = own_address_ff;

endmodule

@@ src/mbrtu_frame_fsm.sv @@
module mbrtu_frame_fsm
   import mbrtu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  item_type   item,
   input  logic [7:0] own_address,
   output result_type result
);

   phase_type   phase_ff, phase_in;
   logic [7:0]  bytes_left_ff, bytes_left_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  crc_low_ff, crc_low_in;
   logic [7:0]  func_ff, func_in;
   logic        bcast_ff, bcast_in;
   logic [7:0]  left_dec;
   logic [15:0] crc_next;

   assign left_dec = bytes_left_ff - 8'd1;
   assign crc_next = crc_feed(crc_ff, item.rx_byte);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         bytes_left_ff <= '0;
         crc_ff        <= CRC_PRESET;
         crc_low_ff    <= '0;
         func_ff       <= '0;
         bcast_ff      <= 1'b0;
      end else if (fire) begin
         phase_ff      <= phase_in;
         bytes_left_ff <= bytes_left_in;
         crc_ff        <= crc_in;
         crc_low_ff    <= crc_low_in;
         func_ff       <= func_in;
         bcast_ff      <= bcast_in;
      end
   end

   always_comb begin
      phase_in      = phase_ff;
      bytes_left_in = bytes_left_ff;
      crc_in        = crc_ff;
      crc_low_in    = crc_low_ff;
      func_in       = func_ff;
      bcast_in      = bcast_ff;
      result        = '0;
      if (item.kind == KIND_SILENCE) begin
         result.frame_dropped = (phase_ff != PH_IDLE) && (phase_ff != PH_DISCARD);
         phase_in      = PH_IDLE;
         bytes_left_in = '0;
      end else begin
         unique case (phase_ff)
            PH_IDLE: begin
               if ((item.rx_byte == BCAST_ADDR) || (item.rx_byte == own_address)) begin
                  bcast_in      = (item.rx_byte == BCAST_ADDR);
                  bytes_left_in = BASE_COUNT;
                  crc_in        = crc_feed(CRC_PRESET, item.rx_byte);
                  phase_in      = PH_FUNC;
               end else begin
                  phase_in = PH_DISCARD;
               end
            end
            PH_FUNC: begin
               func_in = item.rx_byte;
               crc_in  = crc_next;
               if (item.rx_byte != FN_WRITE_MULT) begin
                  bytes_left_in = left_dec;
               end
               phase_in = PH_DATA;
            end
            PH_DATA: begin
               result.payload_valid = 1'b1;
               result.payload_byte  = item.rx_byte;
               crc_in        = crc_next;
               bytes_left_in = left_dec;
               if (left_dec == 8'd0) begin
                  if ((func_ff == FN_WRITE_MULT) && (item.rx_byte != 8'd0)) begin
                     bytes_left_in = item.rx_byte;
                     phase_in      = PH_EXTRA;
                  end else begin
                     phase_in = PH_CRCL;
                  end
               end
            end
            PH_EXTRA: begin
               result.payload_valid = 1'b1;
               result.payload_byte  = item.rx_byte;
               crc_in        = crc_next;
               bytes_left_in = left_dec;
               if (left_dec == 8'd0) begin
                  phase_in = PH_CRCL;
               end
            end
            PH_CRCL: begin
               crc_low_in = item.rx_byte;
               phase_in   = PH_CRCH;
            end
            PH_CRCH: begin
               result.frame_end     = 1'b1;
               result.crc_ok        = ({item.rx_byte, crc_low_ff} == crc_ff);
               result.function_code = func_ff;
               result.is_broadcast  = bcast_ff;
               result.frame_dropped = !result.crc_ok;
               phase_in = PH_IDLE;
            end
            PH_DISCARD: begin
            end
            default: begin
               phase_in = PH_IDLE;
               result.frame_dropped = 1'b1;
            end
         endcase
      end
   end

   // a payload byte never coincides with the end of a frame
   assert property (@(posedge clock) disable iff (reset)
      result.payload_valid |-> !result.frame_end)
      else $error("payload byte reported on frame end");

   // crc status only accompanies a frame end
   assert property (@(posedge clock) disable iff (reset)
      result.crc_ok |-> (result.frame_end && !result.frame_dropped))
      else $error("crc_ok without a clean frame end");

   // a completed frame leaves the parser idle
   assert property (@(posedge clock) disable iff (reset)
      (fire && result.frame_end) |=> (phase_ff == PH_IDLE))
      else $error("parser not idle after frame end");

   // silence always returns to idle
   assert property (@(posedge clock) disable iff (reset)
      (fire && (item.kind == KIND_SILENCE)) |=> (phase_ff == PH_IDLE && bytes_left_ff == 8'd0))
      else $error("parser not idle after silence");

endmodule

@@ src/modbus_rtu_frame_receiver_core.sv @@
// Modbus RTU request receiver. Each req transfer is one event: a UART byte
// (tuser = 0) or a t3.5 line silence (tuser = 1). Each event gives exactly one
// rsp transfer: in_item_ff registers the event and out_ff its parser result. One
// event is taken every cycle while rsp_tready does not stall the output, set by the
// single registered pass through the parser and its byte-wide crc-16 update (poly
// 0xA001, preset 0xFFFF). Payload bytes are flagged on rsp_tuser, and rsp_tlast
// marks the crc high byte, which carries crc_ok, the function code and the broadcast
// flag. own_address lives at byte address 0 of the csr port and resets to 2.
module modbus_rtu_frame_receiver_core
   import mbrtu_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // rx_byte
   input  logic                  req_tuser,   // kind
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // payload_byte, crc_ok, function_code,
                                              // is_broadcast, frame_dropped, zero pad
   output logic                  rsp_tuser,   // payload_valid
   output logic                  rsp_tlast,   // frame_end
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   logic       in_valid_ff, in_valid_in;
   item_type   in_item_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff;
   result_type result;
   logic       advance;
   logic       accept;
   logic [7:0] own_address;

   mbrtu_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .own_address (own_address)
   );

   mbrtu_frame_fsm u_fsm (
      .clock       (clock),
      .reset       (reset),
      .fire        (advance),
      .item        (in_item_ff),
      .own_address (own_address),
      .result      (result)
   );

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff.kind    <= req_tuser;
         in_item_ff.rx_byte <= req_tdata;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.payload_valid;
   assign rsp_tlast  = out_ff.frame_end;
   assign rsp_tdata  = {5'b00000, out_ff.frame_dropped, out_ff.is_broadcast,
                        out_ff.function_code, out_ff.crc_ok, out_ff.payload_byte};

endmodule
